// ===== sv/psd_pkg.sv =====
// package for point_segment_distance: widths, pipeline words, latency
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;
  localparam int COORD_BITS = 24;
  localparam int T_BITS     = 16;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = 2 * DW;
  localparam int NW         = PW + 1;
  localparam int MW         = T_BITS + 2 + DW;
  localparam int SQ_STEPS   = COORD_BITS + 1;
  localparam int PIPE_LAT   = 3 + T_BITS + 4 + SQ_STEPS + 1;
  localparam logic [T_BITS:0] T_ONE = (T_BITS + 1)'(1) << T_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
  } geo_t;

  typedef struct packed {
    logic              vld;
    logic              sat;
    logic [T_BITS-1:0] q;
    logic [NW-1:0]     rem;
    logic [NW-1:0]     den;
    geo_t              geo;
  } div_t;

  typedef struct packed {
    logic                         vld;
    logic [NW-1:0]                n;
    logic [NW-1:0]                res;
    logic [T_BITS:0]              t;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
  } sq_t;
endpackage
`default_nettype wire

// ===== sv/psd_div_cell.sv =====
// one quotient bit of the projection parameter divide, registered
// depends on psd_pkg
`timescale 1ns / 1ps
`default_nettype none
module psd_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire psd_pkg::div_t d_in,
  output psd_pkg::div_t      d_out
);
  import psd_pkg::*;

  logic [NW-1:0] shl;
  div_t          nxt;

  always_comb begin
    shl = {d_in.rem[NW-2:0], 1'b0};
    nxt = d_in;
    if (shl >= d_in.den) begin
      nxt.rem = shl - d_in.den;
      nxt.q   = {d_in.q[T_BITS-2:0], 1'b1};
    end else begin
      nxt.rem = shl;
      nxt.q   = {d_in.q[T_BITS-2:0], 1'b0};
    end
    if (!rst_n) begin
      nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end
endmodule
`default_nettype wire

// ===== sv/psd_sqrt_cell.sv =====
// one result bit of the integer square root, registered
// depends on psd_pkg
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [psd_pkg::NW-1:0] bitv,
  input  wire psd_pkg::sq_t           s_in,
  output psd_pkg::sq_t                s_out
);
  import psd_pkg::*;

  logic [NW-1:0] trial;
  sq_t           nxt;

  always_comb begin
    trial = s_in.res + bitv;
    nxt   = s_in;
    if (s_in.n >= trial) begin
      nxt.n   = s_in.n - trial;
      nxt.res = (s_in.res >> 1) + bitv;
    end else begin
      nxt.res = s_in.res >> 1;
    end
    if (!rst_n) begin
      nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s_out <= nxt;
  end
endmodule
`default_nettype wire

// ===== sv/point_segment_distance.sv =====
// point to segment distance: diff, dot products, divide cells, projection,
// squared error, square root cells; uses psd_pkg, psd_div_cell, psd_sqrt_cell
// one word accepted every cycle; the pipeline is 3 front stages, 16 divide cells,
// 4 projection stages, 25 square root cells and the output register
// busy stays low; the receiver cannot stall and each result shows for one cycle
// synchronous reset clears every valid bit in the pipeline
`timescale 1ns / 1ps
`default_nettype none
module point_segment_distance (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [psd_pkg::COORD_BITS-1:0] in_point_x,
  input  wire logic signed [psd_pkg::COORD_BITS-1:0] in_point_y,
  input  wire logic signed [psd_pkg::COORD_BITS-1:0] in_start_x,
  input  wire logic signed [psd_pkg::COORD_BITS-1:0] in_start_y,
  input  wire logic signed [psd_pkg::COORD_BITS-1:0] in_end_x,
  input  wire logic signed [psd_pkg::COORD_BITS-1:0] in_end_y,
  output logic                                      out_valid,
  output logic [psd_pkg::COORD_BITS:0]              out_distance,
  output logic signed [psd_pkg::COORD_BITS-1:0]     out_proj_x,
  output logic signed [psd_pkg::COORD_BITS-1:0]     out_proj_y,
  output logic [psd_pkg::T_BITS:0]                  out_seg_position
);
  import psd_pkg::*;

  logic                  v0_r, v1_r, v2_r;
  geo_t                  g0_r, g1_r, g2_r;
  logic signed [DW-1:0]  vx_r, vy_r;
  logic signed [PW-1:0]  mxx_r, myy_r, sxx_r, syy_r;
  logic [NW-1:0]         num_r, den_r;
  div_t                  dch [0:T_BITS];
  logic                  zero, sat;
  logic [T_BITS:0]       t_fin;

  logic                  p1_r, p2_r, p3_r, p4_r;
  logic signed [MW-1:0]  mpx_r, mpy_r;
  logic [T_BITS:0]       t1_r, t2_r, t3_r, t4_r;
  logic signed [COORD_BITS-1:0] px1_r, py1_r, ax1_r, ay1_r, px2_r, py2_r;
  logic signed [COORD_BITS-1:0] qx2_r, qy2_r, qx3_r, qy3_r, qx4_r, qy4_r;
  logic signed [DW-1:0]  qx_nxt, qy_nxt;
  logic signed [DW-1:0]  ex_r, ey_r;
  logic signed [PW-1:0]  exx_r, eyy_r;
  sq_t                   sch [0:SQ_STEPS];

  assign busy = 1'b0;

  // front: differences, products, sums
  always_ff @(posedge clk) begin
    g0_r.px <= in_point_x;
    g0_r.py <= in_point_y;
    g0_r.ax <= in_start_x;
    g0_r.ay <= in_start_y;
    g0_r.dx <= DW'(in_end_x) - DW'(in_start_x);
    g0_r.dy <= DW'(in_end_y) - DW'(in_start_y);
    vx_r    <= DW'(in_point_x) - DW'(in_start_x);
    vy_r    <= DW'(in_point_y) - DW'(in_start_y);
    g1_r    <= g0_r;
    mxx_r   <= vx_r * g0_r.dx;
    myy_r   <= vy_r * g0_r.dy;
    sxx_r   <= g0_r.dx * g0_r.dx;
    syy_r   <= g0_r.dy * g0_r.dy;
    g2_r    <= g1_r;
    num_r   <= {mxx_r[PW-1], mxx_r} + {myy_r[PW-1], myy_r};
    den_r   <= {1'b0, sxx_r} + {1'b0, syy_r};
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // clamp classification and divide seed
  always_comb begin
    zero       = (den_r == '0) || num_r[NW-1] || (num_r == '0);
    sat        = !zero && (num_r >= den_r);
    dch[0].vld = v2_r;
    dch[0].sat = sat;
    dch[0].q   = '0;
    dch[0].rem = (zero || sat) ? '0 : num_r;
    dch[0].den = (zero || sat) ? '1 : den_r;
    dch[0].geo = g2_r;
  end

  for (genvar k = 0; k < T_BITS; k++) begin : g_div
    psd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (dch[k]),
      .d_out (dch[k+1])
    );
  end

  assign t_fin  = dch[T_BITS].sat ? T_ONE : {1'b0, dch[T_BITS].q};
  assign qx_nxt = DW'(ax1_r) + DW'(mpx_r >>> T_BITS);
  assign qy_nxt = DW'(ay1_r) + DW'(mpy_r >>> T_BITS);

  // projection and squared error
  always_ff @(posedge clk) begin
    mpx_r <= $signed({1'b0, t_fin}) * dch[T_BITS].geo.dx;
    mpy_r <= $signed({1'b0, t_fin}) * dch[T_BITS].geo.dy;
    t1_r  <= t_fin;
    px1_r <= dch[T_BITS].geo.px;
    py1_r <= dch[T_BITS].geo.py;
    ax1_r <= dch[T_BITS].geo.ax;
    ay1_r <= dch[T_BITS].geo.ay;
    qx2_r <= qx_nxt[COORD_BITS-1:0];
    qy2_r <= qy_nxt[COORD_BITS-1:0];
    px2_r <= px1_r;
    py2_r <= py1_r;
    t2_r  <= t1_r;
    ex_r  <= DW'(px2_r) - DW'(qx2_r);
    ey_r  <= DW'(py2_r) - DW'(qy2_r);
    qx3_r <= qx2_r;
    qy3_r <= qy2_r;
    t3_r  <= t2_r;
    exx_r <= ex_r * ex_r;
    eyy_r <= ey_r * ey_r;
    qx4_r <= qx3_r;
    qy4_r <= qy3_r;
    t4_r  <= t3_r;
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
      p3_r <= 1'b0;
      p4_r <= 1'b0;
    end else begin
      p1_r <= dch[T_BITS].vld;
      p2_r <= p1_r;
      p3_r <= p2_r;
      p4_r <= p3_r;
    end
  end

  always_comb begin
    sch[0].vld = p4_r;
    sch[0].n   = {1'b0, exx_r} + {1'b0, eyy_r};
    sch[0].res = '0;
    sch[0].t   = t4_r;
    sch[0].qx  = qx4_r;
    sch[0].qy  = qy4_r;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [NW-1:0] BITV = NW'(1) << (2 * (SQ_STEPS - 1 - k));
    psd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .bitv  (BITV),
      .s_in  (sch[k]),
      .s_out (sch[k+1])
    );
  end

  always_ff @(posedge clk) begin
    out_distance     <= sch[SQ_STEPS].res[COORD_BITS:0];
    out_proj_x       <= sch[SQ_STEPS].qx;
    out_proj_y       <= sch[SQ_STEPS].qy;
    out_seg_position <= sch[SQ_STEPS].t;
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sch[SQ_STEPS].vld;
    end
  end
endmodule
`default_nettype wire

// ===== sv/psd_checker.sv =====
// port level checks for point_segment_distance, bound to the top level
// depends on psd_pkg
`timescale 1ns / 1ps
`default_nettype none
module psd_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic signed [psd_pkg::COORD_BITS-1:0] in_start_x,
  input wire logic                                 out_valid,
  input wire logic signed [psd_pkg::COORD_BITS-1:0] out_proj_x,
  input wire logic [psd_pkg::T_BITS:0]             out_seg_position
);
  import psd_pkg::*;

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted word not delivered");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result without a word");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seg_position <= T_ONE))
    else $error("t above one");

  a_t_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_seg_position == '0) |-> (out_proj_x == $past(in_start_x, PIPE_LAT)))
    else $error("projection not at segment start");
endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_start_x       (in_start_x),
  .out_valid        (out_valid),
  .out_proj_x       (out_proj_x),
  .out_seg_position (out_seg_position)
);
`default_nettype wire
